@@ hdl/gfb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfb_pkg: shared definitions for the glyph framebuffer blitter
// Screen geometry, command and status codes, controller/datapath interface
// structs and the 5x7 font ROM lookup.
// ----------------------------------------------------------------------------
package gfb_pkg;

  // Screen geometry and derived store size.
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int GLYPH_COLS    = 5;
  localparam int COL_W         = $clog2(GLYPH_COLS);

  // Field widths of one request and one result.
  localparam int CMD_W    = 2;
  localparam int X_W      = 7;
  localparam int Y_W      = 6;
  localparam int CODE_W   = 8;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_GLYPH   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OFF_SCREEN = 2'd2;

  typedef logic [GLYPH_COLS-1:0][7:0] glyph_cols_t;

  typedef struct packed {
    logic        found;
    glyph_cols_t cols;
  } glyph_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request fields
    logic clr_wr;    // write zero at the sweep counter and advance it
    logic rd_top;    // read the glyph byte in its own page
    logic wr_top;    // write back the merged top byte
    logic rd_bot;    // read the byte in the page below
    logic wr_bot;    // write back the merged spill byte
    logic next_col;  // advance to the next glyph column
    logic rd_byte;   // read the requested byte
  } gfb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // sweep counter is on the last byte
    logic draw_go;   // glyph exists and fits on screen
    logic spill;     // glyph row is not page aligned and the page below exists
    logic col_last;  // current column is the last glyph column
  } gfb_stat_t;

  // Packs five glyph columns, leftmost column in slot zero.
  function automatic glyph_cols_t g5(input logic [7:0] c0, input logic [7:0] c1,
                                     input logic [7:0] c2, input logic [7:0] c3,
                                     input logic [7:0] c4);
    glyph_cols_t r;
    r[0] = c0;
    r[1] = c1;
    r[2] = c2;
    r[3] = c3;
    r[4] = c4;
    return r;
  endfunction

  // Font ROM: maps a character code to its five columns, bit 0 on top.
  function automatic glyph_t glyph_lookup(input logic [CODE_W-1:0] code);
    glyph_t g;
    g.found = 1'b1;
    g.cols  = '0;
    case (code)
      8'h20: g.cols = g5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h25: g.cols = g5(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
      8'h2D: g.cols = g5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      8'h2E: g.cols = g5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      8'h30: g.cols = g5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      8'h31: g.cols = g5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      8'h32: g.cols = g5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'h33: g.cols = g5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      8'h34: g.cols = g5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      8'h35: g.cols = g5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'h36: g.cols = g5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      8'h37: g.cols = g5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      8'h38: g.cols = g5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39: g.cols = g5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      8'h41: g.cols = g5(8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C);
      8'h42: g.cols = g5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h43: g.cols = g5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h44: g.cols = g5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      8'h45: g.cols = g5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h46: g.cols = g5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      8'h47: g.cols = g5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
      8'h48: g.cols = g5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      8'h49: g.cols = g5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      8'h4A: g.cols = g5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      8'h4B: g.cols = g5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      8'h4C: g.cols = g5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h4D: g.cols = g5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      8'h4E: g.cols = g5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      8'h4F: g.cols = g5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'h50: g.cols = g5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h51: g.cols = g5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      8'h52: g.cols = g5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h53: g.cols = g5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      8'h54: g.cols = g5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      8'h55: g.cols = g5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      8'h56: g.cols = g5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      8'h57: g.cols = g5(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
      8'h58: g.cols = g5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      8'h59: g.cols = g5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      8'h5A: g.cols = g5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      8'h61: g.cols = g5(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
      8'h62: g.cols = g5(8'h7F, 8'h48, 8'h44, 8'h44, 8'h38);
      8'h63: g.cols = g5(8'h38, 8'h44, 8'h44, 8'h44, 8'h20);
      8'h64: g.cols = g5(8'h38, 8'h44, 8'h44, 8'h48, 8'h7F);
      8'h65: g.cols = g5(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
      8'h66: g.cols = g5(8'h08, 8'h7E, 8'h09, 8'h01, 8'h02);
      8'h67: g.cols = g5(8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E);
      8'h68: g.cols = g5(8'h7F, 8'h08, 8'h04, 8'h04, 8'h78);
      8'h69: g.cols = g5(8'h00, 8'h44, 8'h7D, 8'h40, 8'h00);
      8'h6A: g.cols = g5(8'h20, 8'h40, 8'h44, 8'h3D, 8'h00);
      8'h6B: g.cols = g5(8'h7F, 8'h10, 8'h28, 8'h44, 8'h00);
      8'h6C: g.cols = g5(8'h00, 8'h41, 8'h7F, 8'h40, 8'h00);
      8'h6D: g.cols = g5(8'h7C, 8'h04, 8'h18, 8'h04, 8'h78);
      8'h6E: g.cols = g5(8'h7C, 8'h08, 8'h04, 8'h04, 8'h78);
      8'h6F: g.cols = g5(8'h38, 8'h44, 8'h44, 8'h44, 8'h38);
      8'h70: g.cols = g5(8'h7C, 8'h14, 8'h14, 8'h14, 8'h08);
      8'h71: g.cols = g5(8'h08, 8'h14, 8'h14, 8'h18, 8'h7C);
      8'h72: g.cols = g5(8'h7C, 8'h08, 8'h04, 8'h04, 8'h08);
      8'h73: g.cols = g5(8'h48, 8'h54, 8'h54, 8'h54, 8'h20);
      8'h74: g.cols = g5(8'h04, 8'h3E, 8'h44, 8'h24, 8'h08);
      8'h75: g.cols = g5(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C);
      8'h76: g.cols = g5(8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C);
      8'h77: g.cols = g5(8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C);
      8'h78: g.cols = g5(8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
      8'h79: g.cols = g5(8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C);
      8'h7A: g.cols = g5(8'h44, 8'h64, 8'h54, 8'h4C, 8'h44);
      8'hB0: g.cols = g5(8'h00, 8'h06, 8'h09, 8'h06, 8'h00);
      default: g.found = 1'b0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

@@ hdl/glyph_framebuffer_blitter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_framebuffer_blitter_unit: 5x7 glyph blitter into a page framebuffer
// Clears the 1-bit-per-pixel store, draws font glyphs into it and reads
// single bytes back.
//
// Channel   Direction  Handshake              Payload
// request   in         start_i && !busy_o     command, x_col, y_row, char_code,
//                                             read_index
// result    out        done_o (one cycle)     status, read_byte
//
// A read fetches the requested byte; a draw reads and writes back each glyph
// column in its own page and, on a spill, the page below; a clear zeroes the
// store. Rejected draws and the unused command finish without store access.
// After reset the store is swept to zero with busy_o high.
// The result is shown for one cycle; busy_o drops in the cycle after it.
// ----------------------------------------------------------------------------
module glyph_framebuffer_blitter_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [gfb_pkg::CMD_W-1:0]     command_i,
  input  wire logic [gfb_pkg::X_W-1:0]       x_col_i,
  input  wire logic [gfb_pkg::Y_W-1:0]       y_row_i,
  input  wire logic [gfb_pkg::CODE_W-1:0]    char_code_i,
  input  wire logic [gfb_pkg::INDEX_W-1:0]   read_index_i,
  output logic                               done_o,
  output logic [gfb_pkg::STATUS_W-1:0]       status_o,
  output logic [7:0]                         read_byte_o
);
  import gfb_pkg::*;

  gfb_cmd_t  cmd;
  gfb_stat_t stat;

  // Sequencer.
  gfb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  // Frame store and arithmetic.
  gfb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .command_i    (command_i),
    .x_col_i      (x_col_i),
    .y_row_i      (y_row_i),
    .char_code_i  (char_code_i),
    .read_index_i (read_index_i),
    .stat_o       (stat),
    .status_o     (status_o),
    .read_byte_o  (read_byte_o)
  );

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block idle right after accepting a request");

  // A result is followed by the idle state.
  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block still busy after a result");

  // Failed draws never return store data.
  a_error_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> (read_byte_o == 8'h00))
    else $error("store data returned with an error status");

  // Only defined status codes are reported.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_DONE || status_o == ST_NO_GLYPH ||
                status_o == ST_OFF_SCREEN))
    else $error("undefined status code");

endmodule
`default_nettype wire

@@ hdl/gfb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfb_ctrl: blitter sequencer
// One-hot state machine that steps the datapath through the clearing sweep,
// the per-column read-modify-write of a draw, and the byte read.
// ----------------------------------------------------------------------------
module gfb_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [gfb_pkg::CMD_W-1:0] command_i,
  input  wire gfb_pkg::gfb_stat_t        stat_i,
  output gfb_pkg::gfb_cmd_t              cmd_o,
  output logic                           busy_o,
  output logic                           done_o
);
  import gfb_pkg::*;

  typedef enum logic [9:0] {
    S_INIT   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_CLEAR  = 10'b0000000100,
    S_CHECK  = 10'b0000001000,
    S_RD_TOP = 10'b0000010000,
    S_WR_TOP = 10'b0000100000,
    S_RD_BOT = 10'b0001000000,
    S_WR_BOT = 10'b0010000000,
    S_RD_BYT = 10'b0100000000,
    S_RESULT = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (command_i)
            CMD_CLEAR: state_d = S_CLEAR;
            CMD_DRAW:  state_d = S_CHECK;
            CMD_READ:  state_d = S_RD_BYT;
            default:   state_d = S_RESULT;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_RESULT;
      end
      S_CHECK: begin
        state_d = stat_i.draw_go ? S_RD_TOP : S_RESULT;
      end
      S_RD_TOP: begin
        cmd_o.rd_top = 1'b1;
        state_d      = S_WR_TOP;
      end
      S_WR_TOP: begin
        cmd_o.wr_top = 1'b1;
        if (stat_i.spill) begin
          state_d = S_RD_BOT;
        end else if (stat_i.col_last) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.next_col = 1'b1;
          state_d        = S_RD_TOP;
        end
      end
      S_RD_BOT: begin
        cmd_o.rd_bot = 1'b1;
        state_d      = S_WR_BOT;
      end
      S_WR_BOT: begin
        cmd_o.wr_bot = 1'b1;
        if (stat_i.col_last) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.next_col = 1'b1;
          state_d        = S_RD_TOP;
        end
      end
      S_RD_BYT: begin
        cmd_o.rd_byte = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESULT);

endmodule
`default_nettype wire

@@ hdl/gfb_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfb_datapath: frame store and draw arithmetic
// Holds the page-layout frame store, the captured request, the glyph columns,
// the column and sweep counters, and the result fields.
// ----------------------------------------------------------------------------
module gfb_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire gfb_pkg::gfb_cmd_t            cmd_i,
  input  wire logic [gfb_pkg::CMD_W-1:0]    command_i,
  input  wire logic [gfb_pkg::X_W-1:0]      x_col_i,
  input  wire logic [gfb_pkg::Y_W-1:0]      y_row_i,
  input  wire logic [gfb_pkg::CODE_W-1:0]   char_code_i,
  input  wire logic [gfb_pkg::INDEX_W-1:0]  read_index_i,
  output gfb_pkg::gfb_stat_t                stat_o,
  output logic [gfb_pkg::STATUS_W-1:0]      status_o,
  output logic [7:0]                        read_byte_o
);
  import gfb_pkg::*;

  logic [7:0]          mem [STORE_BYTES];
  logic [7:0]          rdata_q;
  logic [ADDR_W-1:0]   clr_cnt_q;
  logic [COL_W-1:0]    col_q;
  logic [X_W-1:0]      x_q;
  logic [PAGE_W-1:0]   page_q;
  logic [2:0]          shift_q;
  glyph_cols_t         glyph_q;
  logic [ADDR_W-1:0]   idx_q;
  logic [STATUS_W-1:0] status_q;
  logic                draw_go_q;
  logic                spill_q;
  logic                byte_ok_q;

  glyph_t              glyph_in;
  logic                off_screen;
  logic                spill_in;
  logic [ADDR_W-1:0]   top_addr;
  logic [ADDR_W-1:0]   bot_addr;
  logic [15:0]         shifted;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [7:0]          wr_data;

  // Request decode at accept time.
  assign glyph_in   = glyph_lookup(char_code_i);
  assign off_screen = ((int'(x_col_i) + GLYPH_COLS) > SCREEN_WIDTH) ||
                      (int'(y_row_i) >= SCREEN_HEIGHT);
  assign spill_in   = (y_row_i[2:0] != 3'd0) && ((int'(y_row_i >> 3) + 1) < PAGE_COUNT);

  // Capture the request and derive the result status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= ST_DONE;
      draw_go_q <= 1'b0;
      spill_q   <= 1'b0;
      byte_ok_q <= 1'b0;
    end else if (cmd_i.load) begin
      draw_go_q <= 1'b0;
      spill_q   <= spill_in;
      byte_ok_q <= (command_i == CMD_READ) && (int'(read_index_i) < STORE_BYTES);
      status_q  <= ST_DONE;
      if (command_i == CMD_DRAW) begin
        if (!glyph_in.found) begin
          status_q <= ST_NO_GLYPH;
        end else if (off_screen) begin
          status_q <= ST_OFF_SCREEN;
        end else begin
          draw_go_q <= 1'b1;
        end
      end
    end
  end

  // Payload fields of the captured request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_col_i;
      page_q  <= PAGE_W'(y_row_i >> 3);
      shift_q <= y_row_i[2:0];
      glyph_q <= glyph_in.cols;
      idx_q   <= ADDR_W'(read_index_i);
    end
  end

  // Column counter and clearing sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        col_q     <= '0;
        clr_cnt_q <= '0;
      end else begin
        if (cmd_i.next_col) col_q <= col_q + COL_W'(1);
        if (cmd_i.clr_wr) begin
          clr_cnt_q <= (int'(clr_cnt_q) == STORE_BYTES - 1) ? '0 : clr_cnt_q + ADDR_W'(1);
        end
      end
    end
  end

  // Byte addresses of the current column in its page and the page below.
  assign top_addr = ADDR_W'(x_q) + ADDR_W'(col_q) + ADDR_W'(int'(page_q) * SCREEN_WIDTH);
  assign bot_addr = top_addr + ADDR_W'(SCREEN_WIDTH);
  assign shifted  = {8'h00, glyph_q[col_q]} << shift_q;

  // Store port selection.
  always_comb begin
    rd_en   = cmd_i.rd_top | cmd_i.rd_bot | cmd_i.rd_byte;
    rd_addr = top_addr;
    if (cmd_i.rd_bot)  rd_addr = bot_addr;
    if (cmd_i.rd_byte) rd_addr = idx_q;
    wr_en   = cmd_i.clr_wr | cmd_i.wr_top | cmd_i.wr_bot;
    wr_addr = clr_cnt_q;
    wr_data = 8'h00;
    if (cmd_i.wr_top) begin
      wr_addr = top_addr;
      wr_data = rdata_q | shifted[7:0];
    end
    if (cmd_i.wr_bot) begin
      wr_addr = bot_addr;
      wr_data = rdata_q | shifted[15:8];
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  assign stat_o.clr_last = (int'(clr_cnt_q) == STORE_BYTES - 1);
  assign stat_o.draw_go  = draw_go_q;
  assign stat_o.spill    = spill_q;
  assign stat_o.col_last = (int'(col_q) == GLYPH_COLS - 1);

  assign status_o    = status_q;
  assign read_byte_o = byte_ok_q ? rdata_q : 8'h00;

endmodule
`default_nettype wire
